>>> design/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants for the masked byte pattern scanner.
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int MAX_PATTERN_DEF = 64;
  localparam int POS_W           = 32;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TEXT = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] byte_value;
    logic       care;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic [POS_W-1:0] match_start;
    logic             limit_reached;
  } out_word_t;

  // Controls broadcast from the top level to every cell.
  typedef struct packed {
    logic       text_en;
    logic       load_en;
    logic       clear;
    logic [7:0] byte_value;
    logic       care;
  } cell_bus_t;

  // Word handed from the cell row to the report stage.
  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] start;
    logic             clear;
  } scan_word_t;

endpackage

>>> design/mbps_cell.sv
// ----------------------------------------------------------------------------
// mbps_cell
// One pattern position: holds its pattern byte, care bit and partial-match bit.
// ----------------------------------------------------------------------------
module mbps_cell
  import mbps_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int LEN_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cell_bus_t        bus,
  input  logic [LEN_W-1:0] load_idx,
  input  logic [LEN_W-1:0] last_idx,
  input  logic             match_in,
  output logic             match_nxt,
  output logic             match_out
);

  logic [7:0] pat_r;
  logic       care_r;
  logic       part_r;
  logic       forced;
  logic       byte_eq;

  // First and last pattern bytes are always compared
  assign forced    = (IDX == 0) || (last_idx == LEN_W'(IDX));
  assign byte_eq   = (bus.byte_value == pat_r) || (!care_r && !forced);
  assign match_nxt = match_in && byte_eq;
  assign match_out = part_r;

  always_ff @(posedge clk) begin
    if (bus.load_en && (load_idx == LEN_W'(IDX))) begin
      pat_r  <= bus.byte_value;
      care_r <= bus.care;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r <= 1'b0;
    end else if (bus.clear) begin
      part_r <= 1'b0;
    end else if (bus.text_en) begin
      part_r <= match_nxt;
    end
  end

endmodule

>>> design/mbps_report.sv
// ----------------------------------------------------------------------------
// mbps_report
// Match counting, limit check and the result output register.
// ----------------------------------------------------------------------------
module mbps_report
  import mbps_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             scan_go,
  input  scan_word_t       scan_word,
  input  logic [POS_W-1:0] max_matches,
  output logic             slot_free,
  output logic             out_valid,
  input  logic             out_stall,
  output out_word_t        out_word
);

  logic [POS_W-1:0] cnt_r;
  logic [POS_W-1:0] cnt_inc;
  logic             stopped_r;
  logic             out_valid_r;
  out_word_t        out_word_r;
  logic             emit;
  logic             lim;

  assign slot_free = !out_valid_r || !out_stall;
  assign emit      = scan_go && scan_word.hit && !stopped_r;
  assign cnt_inc   = (cnt_r == {POS_W{1'b1}}) ? cnt_r : cnt_r + 1'b1;
  assign lim       = (max_matches != '0) && (cnt_inc >= max_matches);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      stopped_r <= 1'b0;
    end else if (scan_go) begin
      if (scan_word.clear) begin
        cnt_r     <= '0;
        stopped_r <= 1'b0;
      end else if (emit) begin
        cnt_r     <= cnt_inc;
        stopped_r <= lim;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word_r.match_start   <= scan_word.start;
      out_word_r.limit_reached <= lim;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

>>> design/masked_byte_pattern_scanner.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner
// Masked byte pattern search over a text stream, built as a row of cells.
// ----------------------------------------------------------------------------
//
//   port group  direction  handshake        payload
//   in_*        input      in_valid/stall   in_word_t  (pattern or text word)
//   out_*       output     out_valid/stall  out_word_t (match start, limit)
//   cfg_*       input      cfg_we           cfg_wdata  (max_matches)
//
// One word is taken per cycle when the result side is not stalled. The cell
// row compares a word in the cycle it is accepted and the scan register
// captures the outcome; a result, if any, moves on into the output register
// and is held valid on out_* until it is taken. The scan register
// and the output register each hold one word, so input is stalled only while
// the scan register is full and the output register is full and stalled.
// Reset is synchronous; the pattern store needs no clearing pass.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner
  import mbps_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_word_t         in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output out_word_t        out_word,
  input  logic             cfg_we,
  input  logic [POS_W-1:0] cfg_wdata
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = $clog2(MAX_PATTERN);

  logic [POS_W-1:0]       max_matches_r;
  logic [LEN_W-1:0]       load_cnt_r;
  logic [LEN_W-1:0]       load_cnt_nxt;
  logic [LEN_W-1:0]       len_r;
  logic [LEN_W-1:0]       last_idx;
  logic [POS_W-1:0]       pos_r;
  logic [POS_W-1:0]       pos_inc;
  logic                   accept;
  logic                   load_room;
  cell_bus_t              bus;
  logic [MAX_PATTERN:0]   chain;
  logic [MAX_PATTERN-1:0] part_nxt;
  logic [MAX_PATTERN-1:0] part_vec;
  logic                   hit;
  logic                   scan_valid_r;
  scan_word_t             scan_word_r;
  logic                   slot_free;
  logic                   scan_go;

  // Accept whenever the scan register is empty, or the report stage is empty or drains this cycle
  assign scan_go  = scan_valid_r && slot_free;
  assign in_stall = scan_valid_r && !slot_free;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_matches_r <= '0;
    end else if (cfg_we) begin
      max_matches_r <= cfg_wdata;
    end
  end

  // Broadcast to the cell row
  assign load_room      = (load_cnt_r < LEN_W'(MAX_PATTERN));
  assign bus.text_en    = accept && (in_word.mode == MODE_TEXT);
  assign bus.load_en    = accept && (in_word.mode == MODE_LOAD) && load_room;
  assign bus.clear      = accept && in_word.last;
  assign bus.byte_value = in_word.byte_value;
  assign bus.care       = in_word.care;
  assign last_idx       = len_r - 1'b1;

  // Cell zero always sees a live partial match on its left
  assign chain[0] = 1'b1;

  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    mbps_cell #(
      .IDX   (g),
      .LEN_W (LEN_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .bus       (bus),
      .load_idx  (load_cnt_r),
      .last_idx  (last_idx),
      .match_in  (chain[g]),
      .match_nxt (part_nxt[g]),
      .match_out (part_vec[g])
    );
    assign chain[g+1] = part_vec[g];
  end

  // Full match when the partial bit of the last pattern cell sets
  assign hit = bus.text_en && (len_r != '0) && part_nxt[last_idx[IDX_W-1:0]];

  assign pos_inc      = (pos_r == {POS_W{1'b1}}) ? pos_r : pos_r + 1'b1;
  assign load_cnt_nxt = load_room ? load_cnt_r + 1'b1 : load_cnt_r;

  // Pattern load and text position bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r <= '0;
      len_r      <= '0;
      pos_r      <= '0;
    end else if (accept) begin
      if (in_word.mode == MODE_LOAD) begin
        if (in_word.last) begin
          len_r      <= load_cnt_nxt;
          load_cnt_r <= '0;
          pos_r      <= '0;
        end else begin
          if (load_cnt_r == '0) begin
            len_r <= '0;
          end
          load_cnt_r <= load_cnt_nxt;
        end
      end else begin
        pos_r <= in_word.last ? '0 : pos_inc;
      end
    end
  end

  // Register between the cell row and the report stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_valid_r <= 1'b0;
    end else if (accept) begin
      scan_valid_r <= 1'b1;
    end else if (scan_go) begin
      scan_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scan_word_r.hit   <= hit;
      scan_word_r.start <= pos_inc - POS_W'(len_r);
      scan_word_r.clear <= in_word.last;
    end
  end

  mbps_report u_report (
    .clk         (clk),
    .rst_n       (rst_n),
    .scan_go     (scan_go),
    .scan_word   (scan_word_r),
    .max_matches (max_matches_r),
    .slot_free   (slot_free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word)
  );

  // End of a pattern or text run drops every partial match
  a_clear_parts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_word.last) |=> (part_vec == '0))
    else $error("partial matches survive end of run");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r <= LEN_W'(MAX_PATTERN)) && (load_cnt_r <= LEN_W'(MAX_PATTERN)))
    else $error("pattern length or load count out of range");

  // A fresh pattern load disables matching until it ends
  a_load_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_word.mode == MODE_LOAD) && !in_word.last && (load_cnt_r == '0))
      |=> (len_r == '0))
    else $error("pattern length kept during reload");

  a_no_hit_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r == '0) |-> !hit)
    else $error("match reported without a pattern");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for masked_byte_pattern_scanner. A short directed table
// covers the pattern corner cases and the match limit. Random pattern loads and
// text runs follow across several max_matches settings, all checked word by
// word against a behavioural scanner model kept in this file.
// ----------------------------------------------------------------------------
module testbench;
  import mbps_pkg::*;

  localparam int          MAX_PAT     = MAX_PATTERN_DEF;
  localparam int          PHASE_WORDS = 176;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          HOLD_CYCLES = 160;
  localparam logic [31:0] POS_TOP     = 32'hFFFF_FFFF;

  // How a directed row is checked: by the model, as silent, or as a typed hit.
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_QUIET,
    CHK_HIT
  } row_check_t;

  typedef struct {
    in_word_t    w;
    row_check_t  how;
    logic [31:0] start;
    logic        lim;
  } scan_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;
  logic      cfg_we;
  logic [POS_W-1:0] cfg_wdata;

  masked_byte_pattern_scanner u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Scanner model state: pattern store, text window (entry 0 newest), counters.
  logic [7:0]  pat_byte [MAX_PAT];
  logic        pat_care [MAX_PAT];
  int unsigned pat_len;
  int unsigned load_cnt;
  logic [7:0]  win_byte [MAX_PAT];
  logic [31:0] text_pos;
  logic [31:0] hit_cnt;
  logic        scan_halted;
  logic [31:0] max_hits;

  // Matches the scanner still owes us, oldest first.
  out_word_t   pending_hits [$];

  // Pattern last offered, used to plant matches and to draw bytes for random text.
  logic [7:0]  plant_byte [$];
  logic        plant_care [$];

  scan_row_t   dir_rows [$];
  int          words_taken;
  int          hits_checked;
  int          mismatches;
  int          settings_run;
  int          cycle_cnt;
  int          hold_left;
  bit          held_once;
  bit          steady;

  // --------------------------------------------------------------------------
  // Clock and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d matches outstanding", cycle_cnt,
               pending_hits.size());
      $display("masked_byte_pattern_scanner verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Scanner model
  // --------------------------------------------------------------------------
  function automatic void clear_text();
    for (int k = 0; k < MAX_PAT; k++) win_byte[k] = 8'h00;
    text_pos    = '0;
    hit_cnt     = '0;
    scan_halted = 1'b0;
  endfunction

  // Advance the model by one word; report whether it raises a match.
  function automatic void predict_scan(input in_word_t w, output logic hit,
                                       output out_word_t res);
    logic ok;
    hit = 1'b0;
    res = '0;
    if (w.mode == MODE_LOAD) begin
      // First byte of a load drops the old pattern; overflow bytes are lost.
      if (load_cnt == 0) pat_len = 0;
      if (load_cnt < MAX_PAT) begin
        pat_byte[load_cnt] = w.byte_value;
        pat_care[load_cnt] = w.care;
        load_cnt++;
      end
      if (w.last) begin
        pat_len  = load_cnt;
        load_cnt = 0;
        clear_text();
      end
      return;
    end
    for (int k = MAX_PAT - 1; k > 0; k--) win_byte[k] = win_byte[k-1];
    win_byte[0] = w.byte_value;
    if (text_pos != POS_TOP) text_pos++;
    // Head and tail bytes always compare; inner bytes only where care is set.
    ok = (pat_len != 0) && (text_pos >= pat_len);
    for (int unsigned i = 0; ok && i < pat_len; i++) begin
      if ((i == 0 || i == pat_len - 1 || pat_care[i]) &&
          win_byte[pat_len-1-i] != pat_byte[i])
        ok = 1'b0;
    end
    if (!scan_halted && ok) begin
      if (hit_cnt != POS_TOP) hit_cnt++;
      if (max_hits != 0 && hit_cnt >= max_hits) begin
        res.limit_reached = 1'b1;
        scan_halted       = 1'b1;
      end
      res.match_start = text_pos - 32'(pat_len);
      hit = 1'b1;
    end
    if (w.last) clear_text();
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic note_fault(input string what, input out_word_t exp_w,
                            input out_word_t act_w);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] %s: expected start %0d limit %0b, got start %0d limit %0b",
               $realtime, what, exp_w.match_start, exp_w.limit_reached,
               act_w.match_start, act_w.limit_reached);
  endtask

  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_hits.size() == 0) begin
        note_fault("unexpected match", '0, out_word);
      end else begin
        exp_w = pending_hits.pop_front();
        hits_checked++;
        if (out_word.match_start !== exp_w.match_start ||
            out_word.limit_reached !== exp_w.limit_reached)
          note_fault("match mismatch", exp_w, out_word);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off once traffic is flowing so
  // that both internal stages fill and the input side backs up.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!held_once && words_taken >= 400) begin
      held_once = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = !steady && ($urandom_range(99) < 7);
    end
  end

  // --------------------------------------------------------------------------
  // Sender helpers. All are entered and left just after a falling edge.
  // --------------------------------------------------------------------------
  // Offer one word, hold it until taken, then book its expected match.
  task automatic push_word(input in_word_t w, input row_check_t how,
                           input logic [31:0] t_start, input logic t_lim);
    logic      hit;
    out_word_t res;
    while (!steady && $urandom_range(99) < 7) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_word  = w;
    do @(posedge clk); while (in_stall);
    predict_scan(w, hit, res);
    case (how)
      CHK_MODEL: if (hit) pending_hits = {pending_hits, res};
      CHK_HIT: begin
        res          = '{match_start: t_start, limit_reached: t_lim};
        pending_hits = {pending_hits, res};
      end
      default:   ;
    endcase
    words_taken++;
    @(negedge clk);
  endtask

  // Drain every owed match, then allow for words still inside the pipe that
  // produce nothing before touching the register.
  task automatic settle();
    in_valid = 1'b0;
    while (pending_hits.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_limit(input logic [31:0] v);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
    max_hits  = v;
    settings_run++;
  endtask

  task automatic add_row(input logic mode, input logic [7:0] b, input logic care,
                         input logic last, input row_check_t how,
                         input logic [31:0] start, input logic lim);
    scan_row_t r;
    r.w      = '{mode: mode, byte_value: b, care: care, last: last};
    r.how    = how;
    r.start  = start;
    r.lim    = lim;
    dir_rows = {dir_rows, r};
  endtask

  // A small alphabet or a byte of the last pattern so that matches are common; the rest is any byte.
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 8'h41 + 8'($urandom_range(3));
    if (r < 70 && plant_byte.size() != 0)
      return plant_byte[$urandom_range(plant_byte.size() - 1)];
    return 8'($urandom);
  endfunction

  // Build one pattern load or one text run, and offer it up to the quota.
  task automatic run_episode(inout int sent, input int quota);
    in_word_t    burst [$];
    in_word_t    w;
    logic [7:0]  txt [$];
    int          len;
    int          sel;
    int          target;
    bit          broken;
    bit          end_run;
    sel = $urandom_range(99);
    if (plant_byte.size() == 0 || sel < 14) begin
      // Mostly short patterns, a few long, a few overlong.
      sel    = $urandom_range(99);
      len    = (sel < 80) ? $urandom_range(1, 8) :
               (sel < 94) ? $urandom_range(9, MAX_PAT) : $urandom_range(MAX_PAT + 1, 70);
      broken = ($urandom_range(99) < 6);
      plant_byte.delete();
      plant_care.delete();
      for (int k = 0; k < len; k++) begin
        w.mode       = MODE_LOAD;
        w.byte_value = pick_byte();
        w.care       = 1'($urandom_range(1));
        w.last       = (k == len - 1) && !broken;
        burst        = {burst, w};
        if (k < MAX_PAT) begin
          plant_byte = {plant_byte, w.byte_value};
          plant_care = {plant_care, w.care};
        end
      end
    end else begin
      // Text run: noise with planted copies of the pattern; wildcard and
      // unmarked positions may get arbitrary bytes.
      target = $urandom_range(1, 40) + plant_byte.size();
      while (txt.size() < target) begin
        if ($urandom_range(99) < 35) begin
          foreach (plant_byte[k])
            txt = {txt, ((plant_care[k] || k == 0 || k == plant_byte.size() - 1 ||
                          $urandom_range(1)) ? plant_byte[k] : 8'($urandom))};
        end else begin
          repeat ($urandom_range(1, 4)) txt = {txt, pick_byte()};
        end
      end
      end_run = ($urandom_range(99) < 85);
      foreach (txt[k]) begin
        w.mode       = MODE_TEXT;
        w.byte_value = txt[k];
        w.care       = 1'($urandom_range(1));
        w.last       = ((k == txt.size() - 1) && end_run) || ($urandom_range(99) < 2);
        burst        = {burst, w};
      end
    end
    foreach (burst[k]) begin
      if (sent >= quota) break;
      push_word(burst[k], CHK_MODEL, '0, 1'b0);
      sent++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [31:0] limits [7];
    int          sent;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    out_stall = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    for (int k = 0; k < MAX_PAT; k++) begin
      pat_byte[k] = 8'h00;
      pat_care[k] = 1'b0;
    end
    pat_len  = 0;
    load_cnt = 0;
    max_hits = '0;
    clear_text();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table, run with a limit of two matches per text run.
    set_limit(32'd2);
    // Nothing loaded yet: text never matches.
    add_row(MODE_TEXT, 8'h00, 1'b0, 1'b0, CHK_QUIET, '0, 1'b0);
    add_row(MODE_TEXT, 8'hFF, 1'b1, 1'b1, CHK_QUIET, '0, 1'b0);
    // One-byte pattern with care clear: still compared.
    add_row(MODE_LOAD, 8'hFF, 1'b0, 1'b1, CHK_QUIET, '0, 1'b0);
    add_row(MODE_TEXT, 8'hFF, 1'b0, 1'b0, CHK_HIT, 32'd0, 1'b0);
    add_row(MODE_TEXT, 8'h00, 1'b0, 1'b0, CHK_QUIET, '0, 1'b0);
    add_row(MODE_TEXT, 8'hFF, 1'b0, 1'b0, CHK_HIT, 32'd2, 1'b1);
    // Limit reached: silent until the run ends, then counting restarts.
    add_row(MODE_TEXT, 8'hFF, 1'b0, 1'b1, CHK_QUIET, '0, 1'b0);
    add_row(MODE_TEXT, 8'hFF, 1'b1, 1'b0, CHK_HIT, 32'd0, 1'b0);
    // Reload: three bytes, wildcard middle, tail with care clear.
    add_row(MODE_LOAD, 8'hA5, 1'b1, 1'b0, CHK_QUIET, '0, 1'b0);
    add_row(MODE_LOAD, 8'h00, 1'b0, 1'b0, CHK_QUIET, '0, 1'b0);
    add_row(MODE_LOAD, 8'h5A, 1'b0, 1'b1, CHK_QUIET, '0, 1'b0);
    // Short text first, then a window matching through the wildcard.
    add_row(MODE_TEXT, 8'hA5, 1'b0, 1'b0, CHK_QUIET, '0, 1'b0);
    add_row(MODE_TEXT, 8'h33, 1'b0, 1'b0, CHK_QUIET, '0, 1'b0);
    add_row(MODE_TEXT, 8'h5A, 1'b0, 1'b0, CHK_HIT, 32'd0, 1'b0);
    add_row(MODE_TEXT, 8'h5A, 1'b0, 1'b0, CHK_MODEL, '0, 1'b0);
    add_row(MODE_TEXT, 8'hA5, 1'b1, 1'b0, CHK_MODEL, '0, 1'b0);
    add_row(MODE_TEXT, 8'hA5, 1'b0, 1'b0, CHK_MODEL, '0, 1'b0);
    add_row(MODE_TEXT, 8'h5A, 1'b0, 1'b0, CHK_HIT, 32'd4, 1'b1);
    // Two-byte pattern: overlapping matches, last one on the final text word.
    add_row(MODE_LOAD, 8'h80, 1'b1, 1'b0, CHK_QUIET, '0, 1'b0);
    add_row(MODE_LOAD, 8'h80, 1'b0, 1'b1, CHK_QUIET, '0, 1'b0);
    add_row(MODE_TEXT, 8'h80, 1'b0, 1'b0, CHK_QUIET, '0, 1'b0);
    add_row(MODE_TEXT, 8'h80, 1'b0, 1'b0, CHK_HIT, 32'd0, 1'b0);
    add_row(MODE_TEXT, 8'h80, 1'b0, 1'b1, CHK_HIT, 32'd1, 1'b1);

    foreach (dir_rows[k])
      push_word(dir_rows[k].w, dir_rows[k].how, dir_rows[k].start, dir_rows[k].lim);

    // Random phases. Each boundary drains the scanner before the limit
    // changes; text runs may span a boundary, so a lowered limit can land
    // below the running count.
    limits[0] = 32'd0;
    limits[1] = 32'd1;
    limits[2] = POS_TOP;
    limits[3] = 32'd3;
    limits[4] = 32'($urandom_range(2, 6));
    limits[5] = 32'h8000_0000;
    limits[6] = 32'd0;
    foreach (limits[p]) begin
      settle();
      set_limit(limits[p]);
      steady = (p == 2);
      sent   = 0;
      while (sent < PHASE_WORDS) run_episode(sent, PHASE_WORDS);
    end
    steady   = 1'b0;
    in_valid = 1'b0;

    // Drain, then give the pipe time to show any stray match.
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d words scanned under %0d limit settings, %0d matches checked",
             words_taken, settings_run, hits_checked);
    $display("%0d mismatches, %0d matches still owed", mismatches,
             pending_hits.size());
    if (mismatches == 0 && pending_hits.size() == 0) begin
      $display("masked_byte_pattern_scanner verification clean");
    end else begin
      $display("masked_byte_pattern_scanner verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
design/mbps_pkg.sv
design/mbps_cell.sv
design/mbps_report.sv
design/masked_byte_pattern_scanner.sv
tb/testbench.sv
